>>> hdl/ffe_pkg.sv
// shared constants, types and helper functions of the feedforward/feedback echo
package ffe_pkg;

   // geometry of the echo stores (store depth is a power of two)
   localparam int BUF_DEPTH   = 65536;
   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;

   localparam int POS_W     = $clog2(BUF_DEPTH);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W    = CH_W + POS_W;
   localparam int MEM_DEPTH = 2 ** ADDR_W;

   // arithmetic widths
   localparam int COEF_W     = 16;
   localparam int PROD_W     = SAMPLE_BITS + COEF_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int GAIN_FRAC  = 14;
   localparam int REGEN_FRAC = 15;

   // stream and register port widths
   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic signed [ACC_W-1:0] ACC_HI =
      ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] Y_ROUND = ACC_W'(1) <<< (GAIN_FRAC - 1);
   localparam logic signed [ACC_W-1:0] S_ROUND = ACC_W'(1) <<< (REGEN_FRAC - 1);

   // register indexes of the configuration port
   typedef enum logic [CSR_AW-1:0] {
      CSR_DELAY_IN  = 3'd0,
      CSR_DELAY_OUT = 3'd1,
      CSR_GAIN_DIR  = 3'd2,
      CSR_GAIN_FWD  = 3'd3,
      CSR_GAIN_REC  = 3'd4,
      CSR_REGEN     = 3'd5
   } csr_idx_type;

   typedef logic signed [SAMPLE_BITS-1:0] smp_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [CSR_DW-1:0] delay_in;
      logic [CSR_DW-1:0] delay_out;
      logic [CSR_DW-1:0] gain_direct;
      logic [CSR_DW-1:0] gain_forward;
      logic [CSR_DW-1:0] gain_recursive;
      logic [CSR_DW-1:0] regen;
   } cfg_type;

   // pending store write of an item still in flight
   typedef struct packed {
      logic              valid;
      logic              bypass;
      logic [ADDR_W-1:0] waddr;
   } track_type;

   // item in the read stage, store data arrives alongside
   typedef struct packed {
      logic                   valid;
      logic                   bypass;
      logic                   xd_ok;
      logic                   yd_ok;
      logic [ADDR_W-1:0]      waddr;
      logic [SAMPLE_BITS-1:0] x;
   } s1_type;

   // true when an in-flight item will still write the given entry
   function automatic logic wr_hit(input track_type t, input logic [ADDR_W-1:0] a);
      return t.valid && !t.bypass && (t.waddr == a);
   endfunction

   // clamp a wide signed value to the sample range
   function automatic smp_type sat_smp(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      if (v > ACC_HI) begin
         c = ACC_HI;
      end else if (v < ACC_LO) begin
         c = ACC_LO;
      end else begin
         c = v;
      end
      return c[SAMPLE_BITS-1:0];
   endfunction

endpackage

>>> hdl/feedforward_feedback_echo_core.sv
// Per-channel feedforward/feedback echo: input and output delay stores in two rams.
// Path: an accepted item passes the read, multiply and sum stages before its result is valid.
// Throughput: one item per cycle while the result side is ready; when a delayed read hits
//   a store entry whose write is still in the two stages ahead, intake waits for it, so
//   delays of 1 or 2 on one channel slow intake (the store read/modify/write loop).
// Reset: synchronous; no clearing pass, per-channel write positions and wrap flags make
//   never-written store entries read as zero from the first cycle after reset.
module feedforward_feedback_echo_core import ffe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,  // sample_in
   input  logic              req_tuser,  // chan
   // result items
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,  // sample_out
   // configuration writes
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfg_type                cfg;
   s1_type                 s1;
   track_type              s2_track;
   logic                   s2_ready;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr_in;
   logic [ADDR_W-1:0]      rd_addr_out;
   logic [SAMPLE_BITS-1:0] in_q;
   logic [SAMPLE_BITS-1:0] out_q;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [SAMPLE_BITS-1:0] st_wdata;
   logic [SAMPLE_BITS-1:0] y_wdata;

   // register file
   ffe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // intake and read issue
   ffe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .s2_ready    (s2_ready),
      .s2_track    (s2_track),
      .s1          (s1),
      .rd_en       (rd_en),
      .rd_addr_in  (rd_addr_in),
      .rd_addr_out (rd_addr_out)
   );

   // delayed input store
   ffe_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_in_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (st_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_in),
      .rd_data (in_q)
   );

   // delayed output store
   ffe_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_out_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (y_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_out),
      .rd_data (out_q)
   );

   // arithmetic and result
   ffe_math u_math (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .s1         (s1),
      .in_q       (in_q),
      .out_q      (out_q),
      .s2_ready   (s2_ready),
      .s2_track   (s2_track),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .st_wdata   (st_wdata),
      .y_wdata    (y_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/ffe_ram.sv
// generic simple dual-port ram, one write and one registered read port
module ffe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read-first registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ffe_csr.sv
// configuration registers of the echo
module ffe_csr import ffe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_DELAY_IN:  cfg_in.delay_in       = csr_wdata;
            CSR_DELAY_OUT: cfg_in.delay_out      = csr_wdata;
            CSR_GAIN_DIR:  cfg_in.gain_direct    = csr_wdata;
            CSR_GAIN_FWD:  cfg_in.gain_forward   = csr_wdata;
            CSR_GAIN_REC:  cfg_in.gain_recursive = csr_wdata;
            CSR_REGEN:     cfg_in.regen          = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   // unity direct gain, everything else cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_in       <= '0;
         cfg_ff.delay_out      <= '0;
         cfg_ff.gain_direct    <= CSR_DW'(1 << GAIN_FRAC);
         cfg_ff.gain_forward   <= '0;
         cfg_ff.gain_recursive <= '0;
         cfg_ff.regen          <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/ffe_front.sv
// item intake: write positions, store read issue, hazard interlock, read stage
module ffe_front import ffe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              req_tuser,
   input  logic              s2_ready,
   input  track_type         s2_track,
   output s1_type            s1,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr_in,
   output logic [ADDR_W-1:0] rd_addr_out
);

   logic [POS_W-1:0]    wp_ff [CHANNELS];
   logic [CHANNELS-1:0] wrap_ff;
   s1_type              s1_ff, s1_in;

   logic              chan_bad;
   logic              bypass;
   logic              hazard;
   logic              accept;
   logic              s1_ready;
   logic [CH_W-1:0]   ch;
   logic [POS_W-1:0]  wp;
   logic [POS_W-1:0]  wp_step;
   logic [POS_W-1:0]  rpos_in;
   logic [POS_W-1:0]  rpos_out;
   logic [ADDR_W-1:0] ra_in;
   logic [ADDR_W-1:0] ra_out;
   track_type         s1_track;

   // read positions and the interlock against writes still in flight
   always_comb begin
      chan_bad = (int'(req_tuser) >= CHANNELS);
      ch       = chan_bad ? '0 : CH_W'(req_tuser);
      bypass   = (cfg.delay_in == '0) || (cfg.delay_out == '0) || chan_bad;
      wp       = wp_ff[ch];
      wp_step  = wp + POS_W'(1);
      rpos_in  = wp - POS_W'(cfg.delay_in);
      rpos_out = wp - POS_W'(cfg.delay_out);
      ra_in    = {ch, rpos_in};
      ra_out   = {ch, rpos_out};

      s1_track.valid  = s1_ff.valid;
      s1_track.bypass = s1_ff.bypass;
      s1_track.waddr  = s1_ff.waddr;

      hazard = !bypass &&
               (wr_hit(s1_track, ra_in) || wr_hit(s1_track, ra_out) ||
                wr_hit(s2_track, ra_in) || wr_hit(s2_track, ra_out));

      s1_ready   = !s1_ff.valid || s2_ready;
      req_tready = s1_ready && !hazard;
      accept     = req_tvalid && req_tready;

      // load the read stage; entries never written read as zero
      s1_in = s1_ff;
      if (s1_ready) begin
         s1_in.valid  = accept;
         s1_in.bypass = bypass;
         s1_in.xd_ok  = wrap_ff[ch] || (rpos_in < wp);
         s1_in.yd_ok  = wrap_ff[ch] || (rpos_out < wp);
         s1_in.waddr  = {ch, wp};
         s1_in.x      = req_tdata[SAMPLE_BITS-1:0];
      end
   end

   // per-channel write position and wrap flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i] <= '0;
         end
         wrap_ff <= '0;
      end else if (accept && !bypass) begin
         wp_ff[ch] <= wp_step;
         if (wp_step == '0) begin
            wrap_ff[ch] <= 1'b1;
         end
      end
   end

   // read stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   assign s1          = s1_ff;
   assign rd_en       = accept;
   assign rd_addr_in  = ra_in;
   assign rd_addr_out = ra_out;

endmodule

>>> hdl/ffe_math.sv
// products, sum with rounding and saturation, store write-back, result register
module ffe_math import ffe_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  s1_type                 s1,
   input  logic [SAMPLE_BITS-1:0] in_q,
   input  logic [SAMPLE_BITS-1:0] out_q,
   output logic                   s2_ready,
   output track_type              s2_track,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [SAMPLE_BITS-1:0] st_wdata,
   output logic [SAMPLE_BITS-1:0] y_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata
);

   typedef struct packed {
      logic                   valid;
      logic                   bypass;
      logic [ADDR_W-1:0]      waddr;
      logic [SAMPLE_BITS-1:0] x;
      logic [PROD_W-1:0]      p_direct;
      logic [PROD_W-1:0]      p_forward;
      logic [PROD_W-1:0]      p_recursive;
      logic [PROD_W-1:0]      p_regen;
   } s2_type;

   s2_type  s2_ff, s2_in;
   logic    rsp_valid_ff, rsp_valid_in;
   smp_type rsp_smp_ff, rsp_smp_in;

   logic                     out_ready;
   smp_type                  x1, xd, yd, x2, y, st;
   logic signed [COEF_W-1:0] g_dir, g_fwd, g_rec, g_regen;
   logic signed [PROD_W-1:0] m_dir, m_fwd, m_rec, m_regen;
   logic signed [PROD_W-1:0] q_dir, q_fwd, q_rec, q_regen;
   logic signed [ACC_W-1:0]  acc, y_acc, fb, st_sum;

   // multiply stage on the store read data
   always_comb begin
      x1      = s1.x;
      xd      = s1.xd_ok ? smp_type'(in_q) : '0;
      yd      = s1.yd_ok ? smp_type'(out_q) : '0;
      g_dir   = cfg.gain_direct;
      g_fwd   = cfg.gain_forward;
      g_rec   = cfg.gain_recursive;
      g_regen = cfg.regen;
      m_dir   = PROD_W'(x1) * PROD_W'(g_dir);
      m_fwd   = PROD_W'(xd) * PROD_W'(g_fwd);
      m_rec   = PROD_W'(yd) * PROD_W'(g_rec);
      m_regen = PROD_W'(xd) * PROD_W'(g_regen);

      out_ready = !rsp_valid_ff || rsp_tready;
      s2_ready  = !s2_ff.valid || out_ready;

      s2_in = s2_ff;
      if (s2_ready) begin
         s2_in.valid       = s1.valid;
         s2_in.bypass      = s1.bypass;
         s2_in.waddr       = s1.waddr;
         s2_in.x           = s1.x;
         s2_in.p_direct    = m_dir;
         s2_in.p_forward   = m_fwd;
         s2_in.p_recursive = m_rec;
         s2_in.p_regen     = m_regen;
      end
   end

   // sum, round half up, saturate
   always_comb begin
      x2      = s2_ff.x;
      q_dir   = s2_ff.p_direct;
      q_fwd   = s2_ff.p_forward;
      q_rec   = s2_ff.p_recursive;
      q_regen = s2_ff.p_regen;

      acc    = ACC_W'(q_dir) + ACC_W'(q_fwd) - ACC_W'(q_rec) + Y_ROUND;
      y_acc  = acc >>> GAIN_FRAC;
      y      = sat_smp(y_acc);
      fb     = (ACC_W'(q_regen) + S_ROUND) >>> REGEN_FRAC;
      st_sum = fb + ACC_W'(x2);
      st     = sat_smp(st_sum);

      // one store write per item that is not bypassed, as it leaves for the result register
      wr_en    = s2_ff.valid && out_ready && !s2_ff.bypass;
      wr_addr  = s2_ff.waddr;
      st_wdata = st;
      y_wdata  = y;

      s2_track.valid  = s2_ff.valid;
      s2_track.bypass = s2_ff.bypass;
      s2_track.waddr  = s2_ff.waddr;

      rsp_valid_in = out_ready ? s2_ff.valid : rsp_valid_ff;
      rsp_smp_in   = rsp_smp_ff;
      if (out_ready && s2_ff.valid) begin
         rsp_smp_in = s2_ff.bypass ? x2 : y;
      end
   end

   // sum stage and result register
   always_ff @(posedge clock) begin
      rsp_smp_ff <= rsp_smp_in;
      if (reset) begin
         s2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'($unsigned(rsp_smp_ff));

endmodule

>>> tb/feedforward_feedback_echo_core_test.sv
// testbench of the per-channel feedforward/feedback echo core: streamed samples checked
// against a bit-exact echo predictor
`timescale 1ns / 1ps

module feedforward_feedback_echo_core_test;
   import ffe_pkg::*;

   // run geometry
   localparam int RESET_CYCLES = 7;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 600;
   localparam int RANDOM_ITEMS = 2000;
   localparam int TIMEOUT_NS   = 1_000_000;

   // sample range and fixed-point rounding terms
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 64'sd1;
   localparam longint GAIN_HALF  = 64'sd1 <<< (GAIN_FRAC - 1);
   localparam longint REGEN_HALF = 64'sd1 <<< (REGEN_FRAC - 1);

   // register values of interest
   localparam logic [CSR_DW-1:0] GAIN_MAX   = 16'h7FFF;
   localparam logic [CSR_DW-1:0] GAIN_MIN   = 16'h8000;
   localparam logic [CSR_DW-1:0] GAIN_UNITY = 16'h4000;
   localparam logic [CSR_DW-1:0] DELAY_MAX  = 16'hFFFF;

   // register indexes that decode to nothing
   localparam logic [CSR_AW-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_STUTTER} rx_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // sample_in
   logic              req_tuser = 1'b0; // chan
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // sample_out
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   // predictor state: echo settings, delay histories and write positions
   cfg_type          echo_cfg;
   smp_type          in_hist  [CHANNELS][BUF_DEPTH];
   smp_type          out_hist [CHANNELS][BUF_DEPTH];
   logic [POS_W-1:0] in_pos   [CHANNELS];
   logic [POS_W-1:0] out_pos  [CHANNELS];
   smp_type          expected_echo [$];

   // sender and receiver control
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   int          mode_left = 0;
   int          stutter_count = 0;

   // bookkeeping
   int      errors = 0;
   int      items_sent = 0;
   int      bypass_items = 0;
   int      sat_items = 0;
   int      settings_run = 0;
   int      max_stall = 0;
   smp_type want_sample;
   smp_type got_sample;

   feedforward_feedback_echo_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // clamp to the signed sample range
   function automatic smp_type clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return smp_type'(SAMPLE_MAX);
      if (v < SAMPLE_MIN) return smp_type'(SAMPLE_MIN);
      return smp_type'(v);
   endfunction

   // echo output of one accepted sample; advances the channel's histories unless bypassed
   function automatic smp_type predict_echo(input smp_type x, input logic ch);
      logic [POS_W-1:0] wi, wo, ri, ro;
      longint xl, xd, yd, acc, raw_y, raw_st;
      smp_type y;
      if (echo_cfg.delay_in == '0 || echo_cfg.delay_out == '0 || int'(ch) >= CHANNELS) begin
         bypass_items++;
         return x;
      end
      wi = in_pos[ch];
      wo = out_pos[ch];
      ri = wi - POS_W'(echo_cfg.delay_in);
      ro = wo - POS_W'(echo_cfg.delay_out);
      xl = x;
      xd = in_hist[ch][ri];
      yd = out_hist[ch][ro];
      acc = longint'($signed(echo_cfg.gain_direct)) * xl
          + longint'($signed(echo_cfg.gain_forward)) * xd
          - longint'($signed(echo_cfg.gain_recursive)) * yd;
      raw_y = (acc + GAIN_HALF) >>> GAIN_FRAC;
      raw_st = xl + ((xd * longint'($signed(echo_cfg.regen)) + REGEN_HALF) >>> REGEN_FRAC);
      if (raw_y > SAMPLE_MAX || raw_y < SAMPLE_MIN) sat_items++;
      y = clamp_sample(raw_y);
      in_hist[ch][wi] = clamp_sample(raw_st);
      out_hist[ch][wo] = y;
      in_pos[ch] = wi + POS_W'(1);
      out_pos[ch] = wo + POS_W'(1);
      return y;
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_sample = rsp_tdata[SAMPLE_BITS-1:0];
         if (expected_echo.size() == 0) begin
            $error("sample_out: unexpected result, actual %0d", got_sample);
            errors++;
         end else begin
            want_sample = expected_echo.pop_front();
            if (got_sample !== want_sample) begin
               $error("sample_out: expected %0d, actual %0d", want_sample, got_sample);
               errors++;
            end
         end
      end
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      stutter_count++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
         end
         mode_left--;
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:  rsp_tready <= ($urandom_range(0, 3) == 0);
            default:    rsp_tready <= ((stutter_count % 8) < 6);
         endcase
      end
   end

   // offer one item in bursts with random gaps, wait until it is taken
   task automatic send_sample(input smp_type x, input logic ch);
      int stall;
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= DATA_W'($unsigned(x));
      req_tuser <= ch;
      stall = 0;
      @(posedge clock);
      while (!req_tready) begin
         stall++;
         @(posedge clock);
      end
      if (stall > max_stall) max_stall = stall;
      expected_echo.push_back(predict_echo(x, ch));
      items_sent++;
   endtask

   // stop offering and let every outstanding result come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_echo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write, mirrored into the predictor
   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DELAY_IN:  echo_cfg.delay_in = value;
         CSR_DELAY_OUT: echo_cfg.delay_out = value;
         CSR_GAIN_DIR:  echo_cfg.gain_direct = value;
         CSR_GAIN_FWD:  echo_cfg.gain_forward = value;
         CSR_GAIN_REC:  echo_cfg.gain_recursive = value;
         CSR_REGEN:     echo_cfg.regen = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // full echo setting, written once the block is idle
   task automatic set_config(input logic [CSR_DW-1:0] d_in, input logic [CSR_DW-1:0] d_out,
                             input logic [CSR_DW-1:0] g_dir, input logic [CSR_DW-1:0] g_fwd,
                             input logic [CSR_DW-1:0] g_rec, input logic [CSR_DW-1:0] rg);
      wait_idle();
      write_csr(CSR_DELAY_IN, d_in);
      write_csr(CSR_DELAY_OUT, d_out);
      write_csr(CSR_GAIN_DIR, g_dir);
      write_csr(CSR_GAIN_FWD, g_fwd);
      write_csr(CSR_GAIN_REC, g_rec);
      write_csr(CSR_REGEN, rg);
      settings_run++;
   endtask

   // samples weighted toward the range ends and small values
   function automatic smp_type random_sample();
      case ($urandom_range(0, 9))
         0:       return smp_type'(SAMPLE_MAX);
         1:       return smp_type'(SAMPLE_MIN);
         2:       return smp_type'($urandom_range(0, 511)) - smp_type'(256);
         default: return smp_type'($urandom);
      endcase
   endfunction

   // gains: extremes, zero, moderate and full range
   function automatic logic [CSR_DW-1:0] random_gain();
      case ($urandom_range(0, 7))
         0:       return GAIN_MAX;
         1:       return GAIN_MIN;
         2:       return '0;
         3, 4:    return CSR_DW'($urandom_range(0, 32768)) - GAIN_UNITY;
         default: return CSR_DW'($urandom);
      endcase
   endfunction

   // delays: mostly short so echoes build up, sometimes bypass or very long
   function automatic logic [CSR_DW-1:0] random_delay();
      case ($urandom_range(0, 11))
         0:          return '0;
         1, 2, 3:    return CSR_DW'($urandom_range(1, 3));
         4, 5, 6:    return CSR_DW'($urandom_range(4, 40));
         7, 8:       return CSR_DW'($urandom_range(41, 600));
         9:          return DELAY_MAX;
         default:    return CSR_DW'($urandom);
      endcase
   endfunction

   // reset settings pass samples through untouched
   task automatic test_reset_bypass();
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b1);
      send_sample('0, 1'b0);
      send_sample('1, 1'b1);
      send_sample(smp_type'(24'h555555), 1'b0);
      send_sample(smp_type'(24'hAAAAAA), 1'b1);
   endtask

   // writes to undecoded indexes change nothing; one zero delay alone bypasses
   task automatic test_unused_index();
      set_config('0, 16'd3, GAIN_UNITY, GAIN_MAX, GAIN_MIN, GAIN_MAX);
      write_csr(CSR_SPARE_A, 16'h0001);
      write_csr(CSR_SPARE_B, 16'h0001);
      send_sample(smp_type'(24'h123456), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b1);
      set_config(16'd3, '0, GAIN_UNITY, GAIN_MAX, GAIN_MIN, GAIN_MAX);
      write_csr(CSR_SPARE_A, 16'h0001);
      write_csr(CSR_SPARE_B, 16'h0001);
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(24'hFEDCBA), 1'b1);
   endtask

   // extreme gains with the shortest and longest delays, a run on channel 0 and then on both
   task automatic test_saturation();
      set_config(16'd1, 16'd1, GAIN_MAX, GAIN_MIN, GAIN_MIN, GAIN_MAX);
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b0);
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b1);
      send_sample(smp_type'(SAMPLE_MAX), 1'b1);
      set_config(DELAY_MAX, DELAY_MAX, GAIN_MIN, GAIN_MAX, GAIN_MAX, GAIN_MIN);
      send_sample(smp_type'(SAMPLE_MAX), 1'b0);
      send_sample(smp_type'(SAMPLE_MIN), 1'b1);
      send_sample('1, 1'b0);
      send_sample(smp_type'(24'h000001), 1'b1);
   endtask

   // random settings, each followed by a run of random samples
   task automatic test_random_phases();
      int count;
      int phase_len;
      logic ch;
      count = 0;
      ch = 1'b0;
      while (count < RANDOM_ITEMS) begin
         set_config(random_delay(), random_delay(), random_gain(), random_gain(),
                    random_gain(), random_gain());
         phase_len = $urandom_range(80, 240);
         repeat (phase_len) begin
            if ($urandom_range(0, 2) == 0) ch = 1'($urandom_range(0, 1));
            send_sample(random_sample(), ch);
         end
         count += phase_len;
      end
   endtask

   // long result hold-off with short delays while the input keeps streaming
   task automatic test_backpressure();
      set_config(16'd1, 16'd2, random_gain(), random_gain(), random_gain(), random_gain());
      gaps_on = 1'b0;
      hold_request = 1'b1;
      repeat (64) send_sample(random_sample(), 1'($urandom_range(0, 1)));
      gaps_on = 1'b1;
   endtask

   // test sequence
   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         for (int i = 0; i < BUF_DEPTH; i++) begin
            in_hist[c][i] = '0;
            out_hist[c][i] = '0;
         end
         in_pos[c] = '0;
         out_pos[c] = '0;
      end
      echo_cfg = '{delay_in: '0, delay_out: '0, gain_direct: GAIN_UNITY,
                   gain_forward: '0, gain_recursive: '0, regen: '0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_bypass();
      test_unused_index();
      test_saturation();
      test_random_phases();
      test_backpressure();
      wait_idle();
      $display("ran %0d samples under %0d echo settings: %0d bypassed, %0d clipped",
               items_sent, settings_run, bypass_items, sat_items);
      $display("longest intake stall %0d cycles", max_stall);
      if (errors == 0) begin
         $display("feedforward_feedback_echo_core: match");
      end else begin
         $display("feedforward_feedback_echo_core: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("feedforward_feedback_echo_core: mismatch");
      $finish;
   end

endmodule
